/* rtl/btcc_pkg.sv */
// btcc_pkg: shared constants, types and codes for the bind table with cycle check.
// No dependencies; imported by bind_table_cycle_check and btcc_cmp.
package btcc_pkg;

	localparam int MAX_EDGES    = 32;
	localparam int PATH_ID_BITS = 32;
	localparam int FIELD_BITS   = 32;
	localparam int PATH_W       = (PATH_ID_BITS < FIELD_BITS) ? PATH_ID_BITS : FIELD_BITS;
	localparam int ENT_W        = 2 * PATH_W;
	localparam int IDX_W        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CNT_W        = $clog2(MAX_EDGES + 1);

	localparam int STATUS_W     = 3;
	localparam int COUNT_W      = 6;
	localparam int S_TDATA_W    = ((2 * FIELD_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W    = ((STATUS_W + COUNT_W + 7) / 8) * 8;
	localparam int M_PAD_W      = M_TDATA_W - STATUS_W - COUNT_W;

	typedef enum logic [0:0] {
		MODE_BIND   = 1'b0,
		MODE_UNBIND = 1'b1
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_SAME     = 3'd1,
		ST_CYCLE    = 3'd2,
		ST_DUP      = 3'd3,
		ST_FULL     = 3'd4,
		ST_NOTFOUND = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_LOAD,
		S_UNBW,
		S_OUT
	} fsm_t;

	typedef struct packed {
		logic dest_hit;
		logic src_is_dst;
		logic pair_hit;
	} cmp_t;

endpackage

/* rtl/bind_table_cycle_check.sv */
// bind_table_cycle_check: directed edge table with bind/unbind and cycle rejection.
// Depends on btcc_pkg, btcc_ram, btcc_cmp.
//
// Input stream (s_*): one request per transaction. s_tuser[0] is the mode
// (bind or unbind), s_tdata holds src_path then dst_path. Output stream (m_*):
// one result per request, m_tdata holds status then entry_count.
// Only one request is in flight; s_tready is high while the block is idle.
// Each walk reads the held entries one by one through the registered table
// read and the single compare unit. Unbind answers after one walk; when the
// pair is found, the last entry then moves into its slot before the result.
// Bind runs a backward reachability search from the source over the edges that
// lead into it: an initial walk, then one walk per reached edge.
// A detected cycle ends the search early. Same-endpoint binds answer without a walk.
// The next request is accepted in the cycle after the result is delivered.
// Reset clears the entry count and control state; table contents are not
// cleared, and entries beyond the count are never used.
// A stalled receiver holds the result in the output register, and no new
// request is taken until it is delivered.
module bind_table_cycle_check import btcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // src_path, dst_path
	input  logic [0:0]           s_tuser,   // mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // status, entry_count, zero pad
);

	fsm_t                  state_q, state_d;
	mode_t                 mode_q;
	logic [PATH_W-1:0]     src_q, dst_q, v_q;
	logic [CNT_W-1:0]      count_q, issue_q;
	logic                  rv_s1;
	logic [IDX_W-1:0]      ridx_s1;
	logic [MAX_EDGES-1:0]  mark_q, done_q, pend;
	logic                  cyc_q, found_q;
	logic [IDX_W-1:0]      found_idx_q;
	status_t               res_status_q;
	logic [COUNT_W-1:0]    res_count_q;

	logic [PATH_W-1:0]     in_src, in_dst, ent_src, ent_dst;
	logic [IDX_W-1:0]      rd_addr, wr_addr, pick_idx, last_idx;
	logic [ENT_W-1:0]      rd_data, wr_data;
	logic                  we, issue_more, scan_done, pend_any, full;
	cmp_t                  hit;

	assign in_src     = s_tdata[PATH_W-1:0];
	assign in_dst     = s_tdata[FIELD_BITS +: PATH_W];
	assign ent_src    = rd_data[PATH_W-1:0];
	assign ent_dst    = rd_data[ENT_W-1:PATH_W];
	assign issue_more = (issue_q < count_q);
	assign scan_done  = !issue_more && !rv_s1;
	assign pend       = mark_q & ~done_q;
	assign pend_any   = |pend;
	assign full       = (count_q >= CNT_W'(MAX_EDGES));
	assign last_idx   = IDX_W'(count_q - 1'b1);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {{M_PAD_W{1'b0}}, res_count_q, res_status_q};

	btcc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_EDGES),
		.AW    (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	btcc_cmp u_cmp (
		.ent_src (ent_src),
		.ent_dst (ent_dst),
		.key     (v_q),
		.req_src (src_q),
		.req_dst (dst_q),
		.hit     (hit)
	);

	always_comb begin
		pick_idx = '0;
		for (int i = MAX_EDGES - 1; i >= 0; i--) begin
			if (pend[i]) begin
				pick_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = issue_q[IDX_W-1:0];
		we      = 1'b0;
		wr_addr = found_idx_q;
		wr_data = rd_data;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (mode_t'(s_tuser[0]) == MODE_BIND && in_src == in_dst) begin
						state_d = S_OUT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					if (mode_q == MODE_UNBIND) begin
						if (found_q) begin
							rd_addr = last_idx;
							state_d = S_UNBW;
						end else begin
							state_d = S_OUT;
						end
					end else if (cyc_q) begin
						state_d = S_OUT;
					end else begin
						state_d = S_PICK;
					end
				end
			end
			S_PICK: begin
				if (pend_any) begin
					rd_addr = pick_idx;
					state_d = S_LOAD;
				end else begin
					if (!found_q && !full) begin
						we      = 1'b1;
						wr_addr = IDX_W'(count_q);
						wr_data = {dst_q, src_q};
					end
					state_d = S_OUT;
				end
			end
			S_LOAD: begin
				state_d = S_SCAN;
			end
			S_UNBW: begin
				we      = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_BIND;
			src_q        <= '0;
			dst_q        <= '0;
			v_q          <= '0;
			count_q      <= '0;
			issue_q      <= '0;
			rv_s1        <= 1'b0;
			ridx_s1      <= '0;
			mark_q       <= '0;
			done_q       <= '0;
			cyc_q        <= 1'b0;
			found_q      <= 1'b0;
			found_idx_q  <= '0;
			res_status_q <= ST_OK;
			res_count_q  <= '0;
		end else begin
			rv_s1   <= (state_q == S_SCAN) && issue_more;
			ridx_s1 <= issue_q[IDX_W-1:0];
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q       <= mode_t'(s_tuser[0]);
						src_q        <= in_src;
						dst_q        <= in_dst;
						v_q          <= in_src;
						issue_q      <= '0;
						mark_q       <= '0;
						done_q       <= '0;
						cyc_q        <= 1'b0;
						found_q      <= 1'b0;
						res_status_q <= ST_SAME;
						res_count_q  <= COUNT_W'(count_q);
					end
				end
				S_SCAN: begin
					if (issue_more) begin
						issue_q <= issue_q + 1'b1;
					end
					if (rv_s1) begin
						if (mode_q == MODE_BIND && hit.dest_hit && !mark_q[ridx_s1]) begin
							mark_q[ridx_s1] <= 1'b1;
							if (hit.src_is_dst) begin
								cyc_q <= 1'b1;
							end
						end
						if (hit.pair_hit && !found_q) begin
							found_q     <= 1'b1;
							found_idx_q <= ridx_s1;
						end
					end
					if (scan_done) begin
						if (mode_q == MODE_UNBIND) begin
							res_status_q <= ST_NOTFOUND;
						end else begin
							res_status_q <= ST_CYCLE;
						end
					end
				end
				S_PICK: begin
					if (pend_any) begin
						done_q[pick_idx] <= 1'b1;
					end else if (found_q) begin
						res_status_q <= ST_DUP;
					end else if (full) begin
						res_status_q <= ST_FULL;
					end else begin
						count_q      <= count_q + 1'b1;
						res_status_q <= ST_OK;
						res_count_q  <= COUNT_W'(count_q + 1'b1);
					end
				end
				S_LOAD: begin
					v_q     <= ent_src;
					issue_q <= '0;
				end
				S_UNBW: begin
					count_q      <= count_q - 1'b1;
					res_status_q <= ST_OK;
					res_count_q  <= COUNT_W'(count_q - 1'b1);
				end
				default: begin
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_EDGES))
		else $error("entry count exceeds table depth");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> state_q == S_OUT)
		else $error("entry count changed outside request completion");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> ridx_s1 < count_q)
		else $error("table walk read beyond held entries");

	a_cycle_is_bind: assert property (@(posedge clk) disable iff (!arst_n)
		cyc_q |-> mode_q == MODE_BIND)
		else $error("cycle flag raised on unbind");

endmodule

/* rtl/btcc_ram.sv */
// btcc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module btcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/btcc_cmp.sv */
// btcc_cmp: compare unit shared by every table walk; checks one entry per cycle.
// Depends on btcc_pkg.
module btcc_cmp import btcc_pkg::*; (
	input  logic [PATH_W-1:0] ent_src,
	input  logic [PATH_W-1:0] ent_dst,
	input  logic [PATH_W-1:0] key,
	input  logic [PATH_W-1:0] req_src,
	input  logic [PATH_W-1:0] req_dst,
	output cmp_t              hit
);

	always_comb begin
		hit.dest_hit   = (ent_dst == key);
		hit.src_is_dst = (ent_src == req_dst);
		hit.pair_hit   = (ent_src == req_src) && (ent_dst == req_dst);
	end

endmodule

/* bench/bind_table_cycle_check_test.sv */
// Testbench for bind_table_cycle_check: bind/unbind requests with random stream idling.
// Results are checked against an in-bench edge table predictor. Depends on btcc_pkg.
module bind_table_cycle_check_test;
	import btcc_pkg::*;

	localparam int          WATCHDOG_LIMIT = 10000;
	localparam int          HOLDOFF_CYCLES = 2000;
	localparam int          HOLDOFF_AFTER  = 80;
	localparam int          ITEM_TARGET    = 540;
	localparam int          POOL_N         = 10;
	localparam int          REPORT_MAX     = 10;
	localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

	typedef logic [PATH_W-1:0] path_word_t;

	typedef struct {
		status_t              status;
		logic [COUNT_W-1:0]   entries;
	} outcome_t;

	class bind_outcome_board;
		path_word_t   src_tab [MAX_EDGES];
		path_word_t   dst_tab [MAX_EDGES];
		int unsigned  count;
		outcome_t     expected_q [$];
		int unsigned  errors;
		int unsigned  results_seen;

		function bit holds(path_word_t ids [$], path_word_t v);
			foreach (ids[i])
				if (ids[i] == v)
					return 1;
			return 0;
		endfunction

		function int find_pair(path_word_t src, path_word_t dst);
			for (int i = 0; i < count; i++)
				if (src_tab[i] == src && dst_tab[i] == dst)
					return i;
			return -1;
		endfunction

		// grow the set of ids that reach src until stable; dst in it means a loop
		function bit closes_loop(path_word_t src, path_word_t dst);
			path_word_t reach [$];
			bit         grew;
			reach.push_back(src);
			grew = 1;
			while (grew) begin
				grew = 0;
				for (int i = 0; i < count; i++) begin
					if (holds(reach, dst_tab[i]) && !holds(reach, src_tab[i])) begin
						reach.push_back(src_tab[i]);
						grew = 1;
					end
				end
			end
			return holds(reach, dst);
		endfunction

		function void note_request(mode_t mode, path_word_t src, path_word_t dst);
			outcome_t o;
			int       at;
			if (mode == MODE_BIND) begin
				if (src == dst)
					o.status = ST_SAME;
				else if (closes_loop(src, dst))
					o.status = ST_CYCLE;
				else if (find_pair(src, dst) >= 0)
					o.status = ST_DUP;
				else if (count >= MAX_EDGES)
					o.status = ST_FULL;
				else begin
					src_tab[count] = src;
					dst_tab[count] = dst;
					count++;
					o.status = ST_OK;
				end
			end else begin
				at = find_pair(src, dst);
				if (at < 0)
					o.status = ST_NOTFOUND;
				else begin
					src_tab[at] = src_tab[count-1];
					dst_tab[at] = dst_tab[count-1];
					count--;
					o.status = ST_OK;
				end
			end
			o.entries = COUNT_W'(count);
			expected_q.push_back(o);
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= REPORT_MAX)
				$display("%t: %s", $realtime, what);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] word);
			logic [STATUS_W-1:0] got_status;
			logic [COUNT_W-1:0]  got_entries;
			outcome_t            want;
			got_status  = word[STATUS_W-1:0];
			got_entries = word[STATUS_W +: COUNT_W];
			results_seen++;
			if (expected_q.size() == 0) begin
				flag($sformatf("result with nothing pending: status %0d count %0d",
					got_status, got_entries));
				return;
			end
			want = expected_q.pop_front();
			if (got_status !== want.status || got_entries !== want.entries)
				flag($sformatf("result %0d: expected status %0d count %0d, got status %0d count %0d",
					results_seen, want.status, want.entries, got_status, got_entries));
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	bind_outcome_board board = new;
	path_word_t        pool [POOL_N];
	bit                calm;
	int unsigned       sent;
	int unsigned       idle_cycles = 0;

	bind_table_cycle_check DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (s_tvalid && s_tready)
				board.note_request(mode_t'(s_tuser), s_tdata[PATH_W-1:0],
					s_tdata[PATH_W +: PATH_W]);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// called at a falling edge; returns at a falling edge after the transaction
	task automatic offer_request(mode_t mode, path_word_t src, path_word_t dst);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {dst, src};
		do
			@(posedge clk);
		while (!s_tready);
		sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// fill with fresh edges, overflow, rebind a held edge and its reverse, then unbind from the middle and the end
	task automatic run_fill();
		int unsigned k;
		while (board.count < MAX_EDGES)
			offer_request(MODE_BIND, $urandom, $urandom);
		offer_request(MODE_BIND, $urandom, $urandom);
		k = $urandom_range(0, MAX_EDGES - 1);
		offer_request(MODE_BIND, board.src_tab[k], board.dst_tab[k]);
		offer_request(MODE_BIND, board.dst_tab[k], board.src_tab[k]);
		k = MAX_EDGES / 2;
		offer_request(MODE_UNBIND, board.src_tab[k], board.dst_tab[k]);
		k = board.count - 1;
		offer_request(MODE_UNBIND, board.src_tab[k], board.dst_tab[k]);
	endtask

	task automatic offer_random_request();
		int unsigned r;
		int unsigned k;
		path_word_t  a;
		path_word_t  b;
		mode_t       m;
		r = $urandom_range(0, 99);
		m = MODE_BIND;
		a = pool[$urandom_range(0, POOL_N - 1)];
		b = pool[$urandom_range(0, POOL_N - 1)];
		if (r < 8) begin
			a = $urandom;
			b = $urandom;
			m = mode_t'(1'($urandom_range(0, 1)));
		end else if (r < 55) begin
			m = MODE_BIND;
		end else if (r < 65 && board.count > 0) begin
			k = $urandom_range(0, board.count - 1);
			if ($urandom_range(0, 1)) begin
				a = board.src_tab[k];
				b = board.dst_tab[k];
			end else begin
				a = board.dst_tab[k];
				b = board.src_tab[k];
			end
		end else begin
			m = MODE_UNBIND;
			if (board.count > 0 && $urandom_range(0, 9) < 7) begin
				k = $urandom_range(0, board.count - 1);
				a = board.src_tab[k];
				b = board.dst_tab[k];
			end
		end
		offer_request(m, a, b);
	endtask

	initial begin
		int unsigned held;
		int unsigned stall;
		held  = 0;
		stall = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (held == 0 && board.results_seen >= HOLDOFF_AFTER) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = MODE_BIND;
		calm        = 1'b0;
		sent        = 0;
		pool[0] = '0;
		pool[1] = ALL_ONES;
		for (int i = 2; i < POOL_N; i++)
			pool[i] = $urandom;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		offer_request(MODE_UNBIND, '0, '0);
		offer_request(MODE_BIND, 32'd5, 32'd5);
		offer_request(MODE_BIND, '0, ALL_ONES);
		offer_request(MODE_BIND, ALL_ONES, '0);
		offer_request(MODE_BIND, '0, ALL_ONES);
		offer_request(MODE_UNBIND, ALL_ONES, ALL_ONES);
		offer_request(MODE_BIND, 32'd1, '0);
		offer_request(MODE_BIND, ALL_ONES, 32'd1);
		offer_request(MODE_BIND, 32'h5555_5555, 32'hAAAA_AAAA);
		offer_request(MODE_BIND, 32'hAAAA_AAAA, 32'd1);
		offer_request(MODE_BIND, ALL_ONES, 32'h5555_5555);
		offer_request(MODE_UNBIND, 32'd1, '0);
		offer_request(MODE_UNBIND, 32'd1, '0);
		offer_request(MODE_UNBIND, '0, ALL_ONES);
		offer_request(MODE_UNBIND, 32'h5555_5555, 32'hAAAA_AAAA);
		offer_request(MODE_UNBIND, 32'hAAAA_AAAA, 32'd1);

		run_fill();
		while (sent < ITEM_TARGET) begin
			if (sent % 60 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (sent >= ITEM_TARGET / 2 && sent < ITEM_TARGET / 2 + 1)
				run_fill();
			else
				offer_random_request();
		end
		s_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* sim.f */
rtl/btcc_pkg.sv
rtl/btcc_ram.sv
rtl/btcc_cmp.sv
rtl/bind_table_cycle_check.sv
bench/bind_table_cycle_check_test.sv
